// ----- hw/rtl/mbpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_pkg
// Shared types, constants and helpers of the masked bone pose blend pipeline.
// ----------------------------------------------------------------------------
package mbpb_pkg;

  localparam int unsigned MAX_BONES_DEF  = 256;
  localparam int unsigned MASK_BONES_DEF = 32;

  // Configuration register indexes
  localparam logic [7:0] REG_BONE_MASK    = 8'd0;
  localparam logic [7:0] REG_BLEND_WEIGHT = 8'd1;

  localparam logic [31:0] BONE_MASK_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] WEIGHT_RST    = 16'd0;
  localparam logic [15:0] ONE_Q15       = 16'd32768;
  localparam logic [63:0] ID_QUAT       = {16'd16384, 48'd0};

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned QUO_BITS   = 16;

  // Per-bone data carried alongside the rotation arithmetic
  typedef struct packed {
    logic        blend;
    logic        last;
    logic        zero;
    logic [3:0]  neg;
    logic [63:0] base_rot;
    logic [47:0] pos;
    logic [47:0] scl;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [3:0][30:0] mag;
    logic [63:0]     rem;
    logic [63:0]     root;
  } sqrt_t;

  typedef struct packed {
    side_t            side;
    logic [32:0]      dvs;
    logic [3:0][47:0] rem;
    logic [3:0][15:0] quo;
  } div_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] x);
    logic [15:0] r;
    if (x > 18'sd32767) r = 16'h7FFF;
    else if (x < -18'sd32768) r = 16'h8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/masked_bone_pose_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_bone_pose_blend
// Masked per-bone pose blend with lerp on position and scale and nlerp on
// rotation, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one bone per cycle while the output side keeps taking
// results and returns one result per bone, in order, through 55 register
// stages. The stages are five front stages (select, products, sum and lerp,
// squares, length), 32 square-root stages at one root bit each, one divider
// set-up stage, 16 divider stages at one quotient bit each and the output
// register. The whole pipeline holds while a finished result waits at the
// output, so a stall drops nothing. Configuration writes take effect at once
// and are meant for an idle block.
module masked_bone_pose_blend import mbpb_pkg::*; #(
  parameter int unsigned MAX_BONES  = MAX_BONES_DEF,
  parameter int unsigned MASK_BONES = MASK_BONES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  bone_index_i,
  input  logic [63:0] base_rotation_i,
  input  logic [63:0] over_rotation_i,
  input  logic [47:0] base_position_i,
  input  logic [47:0] over_position_i,
  input  logic [47:0] base_scale_i,
  input  logic [47:0] over_scale_i,
  input  logic        last_bone_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_rotation_o,
  output logic [47:0] out_position_o,
  output logic [47:0] out_scale_o,
  output logic        blended_o,
  output logic        final_bone_o
);

  logic [31:0] bone_mask_q;
  logic [15:0] blend_weight_q;
  logic        adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_mask_q    <= BONE_MASK_RST;
      blend_weight_q <= WEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BONE_MASK:    bone_mask_q    <= cfg_data_i;
        REG_BLEND_WEIGHT: blend_weight_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a result waits at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic  sq_valid [SQRT_STEPS+1];
  sqrt_t sq_data  [SQRT_STEPS+1];

  mbpb_front #(
    .MAX_BONES  (MAX_BONES),
    .MASK_BONES (MASK_BONES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .valid_i         (in_valid_i),
    .bone_mask_i     (bone_mask_q),
    .blend_weight_i  (blend_weight_q),
    .bone_index_i    (bone_index_i),
    .base_rotation_i (base_rotation_i),
    .over_rotation_i (over_rotation_i),
    .base_position_i (base_position_i),
    .over_position_i (over_position_i),
    .base_scale_i    (base_scale_i),
    .over_scale_i    (over_scale_i),
    .last_bone_i     (last_bone_i),
    .valid_o         (sq_valid[0]),
    .data_o          (sq_data[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    mbpb_sqrt_step #(.STEP(i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // Divider set-up: numerator |r|*2^15 + s, divisor 2s
  logic dv_valid [QUO_BITS+1];
  div_t dv_data  [QUO_BITS+1];
  logic [31:0] root_s;

  assign root_s = sq_data[SQRT_STEPS].root[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_data[0].side <= sq_data[SQRT_STEPS].side;
      dv_data[0].dvs  <= {root_s, 1'b0};
      dv_data[0].quo  <= '0;
      for (int k = 0; k < 4; k++) begin
        dv_data[0].rem[k] <= {2'b00, sq_data[SQRT_STEPS].mag[k], 15'd0} + {16'd0, root_s};
      end
    end
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    mbpb_div_step #(.QBIT(QUO_BITS - 1 - i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_valid[i]),
      .data_i  (dv_data[i]),
      .valid_o (dv_valid[i+1]),
      .data_o  (dv_data[i+1])
    );
  end

  // Output register: sign, saturate, pick identity or pass-through
  div_t        fin;
  logic [63:0] rot_d;

  assign fin = dv_data[QUO_BITS];

  always_comb begin
    logic signed [17:0] v;
    for (int k = 0; k < 4; k++) begin
      v = fin.side.neg[k] ? -$signed({2'b00, fin.quo[k]}) : $signed({2'b00, fin.quo[k]});
      rot_d[16*k +: 16] = sat16(v);
    end
    if (!fin.side.blend) begin
      rot_d = fin.side.base_rot;
    end else if (fin.side.zero) begin
      rot_d = ID_QUAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dv_valid[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rotation_o <= rot_d;
      out_position_o <= fin.side.pos;
      out_scale_o    <= fin.side.scl;
      blended_o      <= fin.side.blend;
      final_bone_o   <= fin.side.last;
    end
  end

endmodule

// ----- hw/rtl/mbpb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_front
// Selection, weighting products, lerp of position and scale, nlerp sum and
// squared length: five register stages ahead of the square root.
// ----------------------------------------------------------------------------
module mbpb_front import mbpb_pkg::*; #(
  parameter int unsigned MAX_BONES  = MAX_BONES_DEF,
  parameter int unsigned MASK_BONES = MASK_BONES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] bone_mask_i,
  input  logic [15:0] blend_weight_i,
  input  logic [7:0]  bone_index_i,
  input  logic [63:0] base_rotation_i,
  input  logic [63:0] over_rotation_i,
  input  logic [47:0] base_position_i,
  input  logic [47:0] over_position_i,
  input  logic [47:0] base_scale_i,
  input  logic [47:0] over_scale_i,
  input  logic        last_bone_i,
  output logic        valid_o,
  output sqrt_t       data_o
);

  // ---- stage A: select and capture ----
  logic [15:0] t_d;
  logic        sel_d;
  logic [16:0] idx_w;

  always_comb begin
    t_d   = (blend_weight_i > ONE_Q15) ? ONE_Q15 : blend_weight_i;
    idx_w = {9'd0, bone_index_i};
    if (idx_w >= 17'(MAX_BONES)) begin
      sel_d = 1'b0;
    end else if (idx_w < 17'(MASK_BONES)) begin
      sel_d = bone_mask_i[bone_index_i[4:0]];
    end else begin
      sel_d = (bone_mask_i == BONE_MASK_RST);
    end
  end

  logic        va_q;
  logic [63:0] a_q, b_q;
  logic [5:0][15:0] lb_q, lo_q;
  logic [15:0] t_q;
  logic        blend_a_q, last_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q       <= base_rotation_i;
      b_q       <= over_rotation_i;
      lb_q      <= {base_scale_i, base_position_i};
      lo_q      <= {over_scale_i, over_position_i};
      t_q       <= t_d;
      blend_a_q <= sel_d && (t_d != 16'd0);
      last_a_q  <= last_bone_i;
    end
  end

  // ---- stage B: products ----
  logic [3:0][31:0] ab_d, ua_d, tb_d;
  logic [5:0][31:0] lp_d;
  logic [5:0]       ln_d;

  always_comb begin
    logic signed [17:0] u_s, t_s, a18, b18;
    logic signed [35:0] pu, pt, pab;
    logic signed [16:0] dif;
    logic [16:0]        mag;
    logic [32:0]        pm;
    u_s = $signed({2'b00, ONE_Q15 - t_q});
    t_s = $signed({2'b00, t_q});
    for (int k = 0; k < 4; k++) begin
      a18     = 18'($signed(a_q[16*k +: 16]));
      b18     = 18'($signed(b_q[16*k +: 16]));
      pab     = a18 * b18;
      ab_d[k] = pab[31:0];
      pu      = u_s * a18;
      pt      = t_s * b18;
      ua_d[k] = pu[31:0];
      tb_d[k] = pt[31:0];
    end
    for (int k = 0; k < 6; k++) begin
      dif     = 17'($signed(lo_q[k])) - 17'($signed(lb_q[k]));
      ln_d[k] = dif[16];
      mag     = dif[16] ? 17'(-dif) : 17'(dif);
      pm      = {16'd0, mag} * {17'd0, t_q};
      lp_d[k] = pm[31:0];
    end
  end

  logic             vb_q;
  logic [3:0][31:0] ab_q, ua_q, tb_q;
  logic [5:0][31:0] lp_q;
  logic [5:0]       ln_q;
  logic [5:0][15:0] lb_b_q;
  logic [63:0]      rot_b_q;
  logic             blend_b_q, last_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q      <= ab_d;
      ua_q      <= ua_d;
      tb_q      <= tb_d;
      lp_q      <= lp_d;
      ln_q      <= ln_d;
      lb_b_q    <= lb_q;
      rot_b_q   <= a_q;
      blend_b_q <= blend_a_q;
      last_b_q  <= last_a_q;
    end
  end

  // ---- stage C: shortest-path sum and lerp rounding ----
  logic [3:0][31:0] r_d;
  logic [5:0][15:0] lr_d;

  always_comb begin
    logic signed [33:0] dot;
    logic [16:0]        q;
    logic signed [17:0] sum;
    dot = '0;
    for (int k = 0; k < 4; k++) begin
      dot = dot + 34'($signed(ab_q[k]));
    end
    for (int k = 0; k < 4; k++) begin
      r_d[k] = (dot[33] ? -ua_q[k] : ua_q[k]) + tb_q[k];
    end
    for (int k = 0; k < 6; k++) begin
      q   = 17'((33'(lp_q[k]) + 33'd16384) >> 15);
      sum = ln_q[k] ? 18'($signed(lb_b_q[k])) - $signed({1'b0, q})
                    : 18'($signed(lb_b_q[k])) + $signed({1'b0, q});
      lr_d[k] = blend_b_q ? sat16(sum) : lb_b_q[k];
    end
  end

  logic             vc_q;
  logic [3:0][31:0] r_q;
  side_t            side_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q               <= r_d;
      side_c_q.blend    <= blend_b_q;
      side_c_q.last     <= last_b_q;
      side_c_q.zero     <= 1'b0;
      side_c_q.neg      <= '0;
      side_c_q.base_rot <= rot_b_q;
      side_c_q.pos      <= {lr_d[2], lr_d[1], lr_d[0]};
      side_c_q.scl      <= {lr_d[5], lr_d[4], lr_d[3]};
    end
  end

  // ---- stage D: magnitudes and squares ----
  logic [3:0][30:0] m_d;
  logic [3:0][61:0] sq_d;
  logic [3:0]       neg_d;
  side_t            side_d_d;

  always_comb begin
    logic [31:0] ab;
    for (int k = 0; k < 4; k++) begin
      neg_d[k] = r_q[k][31];
      ab       = r_q[k][31] ? -r_q[k] : r_q[k];
      m_d[k]   = ab[30:0];
      sq_d[k]  = {31'd0, m_d[k]} * {31'd0, m_d[k]};
    end
    side_d_d     = side_c_q;
    side_d_d.neg = neg_d;
  end

  logic             vd_q;
  logic [3:0][30:0] m_q;
  logic [3:0][61:0] sq_q;
  side_t            side_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= m_d;
      sq_q     <= sq_d;
      side_d_q <= side_d_d;
    end
  end

  // ---- stage E: squared length ----
  logic [63:0] len_d;
  sqrt_t       data_d;

  always_comb begin
    len_d = '0;
    for (int k = 0; k < 4; k++) begin
      len_d = len_d + 64'(sq_q[k]);
    end
    data_d.side      = side_d_q;
    data_d.side.zero = (len_d == 64'd0);
    data_d.mag       = m_q;
    data_d.rem       = len_d;
    data_d.root      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

// ----- hw/rtl/mbpb_sqrt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_sqrt_step
// One registered iteration of the integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module mbpb_sqrt_step import mbpb_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  localparam logic [63:0] BITV = 64'd1 << (62 - 2 * STEP);

  sqrt_t       data_d;
  logic [63:0] trial;

  always_comb begin
    data_d = data_i;
    trial  = data_i.root + BITV;
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = (data_i.root >> 1) + BITV;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

// ----- hw/rtl/mbpb_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpb_div_step
// One registered restoring-division step, one quotient bit for all four lanes.
// ----------------------------------------------------------------------------
module mbpb_div_step import mbpb_pkg::*; #(
  parameter int unsigned QBIT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  div_t        data_d;
  logic [47:0] dk;

  always_comb begin
    data_d = data_i;
    dk     = {15'd0, data_i.dvs} << QBIT;
    for (int k = 0; k < 4; k++) begin
      if (data_i.rem[k] >= dk) begin
        data_d.rem[k]       = data_i.rem[k] - dk;
        data_d.quo[k][QBIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked bone pose blend: a directed table of
// bones followed by random poses under several mask and weight settings,
// every result compared against a local fixed-point nlerp/lerp predictor.
// ----------------------------------------------------------------------------
module testbench;
  import mbpb_pkg::*;

  typedef struct packed {
    logic [7:0]  idx;
    logic [63:0] brot, orot;
    logic [47:0] bpos, opos, bscl, oscl;
    logic        last;
  } bone_t;

  typedef struct packed {
    logic [63:0] rot;
    logic [47:0] pos, scl;
    logic        blend, last;
  } pose_t;

  typedef struct {
    bone_t b;
    logic  has_exp;
    pose_t e;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] bone_index_i = '0;
  logic [63:0] base_rotation_i = '0, over_rotation_i = '0;
  logic [47:0] base_position_i = '0, over_position_i = '0;
  logic [47:0] base_scale_i = '0, over_scale_i = '0;
  logic last_bone_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] out_rotation_o;
  logic [47:0] out_position_o, out_scale_o;
  logic blended_o, final_bone_o;

  masked_bone_pose_blend uut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  logic [31:0] mask_q;
  logic [15:0] weight_q;
  pose_t expected_poses[$];
  int fail_cnt = 0;
  int n_bones = 0, n_blended = 0, n_results = 0;
  bit stall_on = 1'b1;

  function automatic longint lane_of(logic [63:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic logic [15:0] clamp16(longint x);
    if (x > 32767) return 16'h7FFF;
    if (x < -32768) return 16'h8000;
    return x[15:0];
  endfunction

  function automatic longint root_floor(longint v);
    longint r = 0;
    longint bit_v = 64'sh4000_0000_0000_0000;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >>> 1) + bit_v;
      end else begin
        r = r >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] lerp_lane(longint b, longint o, longint t);
    longint d = o - b;
    longint q = (((d < 0) ? -d : d) * t + 16384) >>> 15;
    return clamp16(b + ((d < 0) ? -q : q));
  endfunction

  function automatic pose_t blend_pose(bone_t b);
    pose_t p;
    longint t, u, dot, len2, s, m, q;
    longint r[4];
    logic sel;
    t = (weight_q > ONE_Q15) ? 32768 : weight_q;
    if (b.idx >= MAX_BONES_DEF) sel = 1'b0;
    else if (b.idx < MASK_BONES_DEF) sel = mask_q[b.idx[4:0]];
    else sel = (mask_q == 32'hFFFF_FFFF);
    p.last = b.last;
    if (!sel || t == 0) begin
      p.rot = b.brot; p.pos = b.bpos; p.scl = b.bscl; p.blend = 1'b0;
      return p;
    end
    p.blend = 1'b1;
    for (int k = 0; k < 3; k++) begin
      p.pos[16*k +: 16] = lerp_lane(lane_of(b.bpos, k), lane_of(b.opos, k), t);
      p.scl[16*k +: 16] = lerp_lane(lane_of(b.bscl, k), lane_of(b.oscl, k), t);
    end
    u = 32768 - t;
    dot = 0;
    for (int k = 0; k < 4; k++) dot += lane_of(b.brot, k) * lane_of(b.orot, k);
    if (dot < 0) u = -u;
    len2 = 0;
    for (int k = 0; k < 4; k++) begin
      r[k] = u * lane_of(b.brot, k) + t * lane_of(b.orot, k);
      len2 += r[k] * r[k];
    end
    if (len2 == 0) begin
      p.rot = ID_QUAT;
      return p;
    end
    s = root_floor(len2);
    for (int k = 0; k < 4; k++) begin
      m = (r[k] < 0) ? -r[k] : r[k];
      q = ((m <<< 15) + s) / (2 * s);
      if (q > 40000) q = 40000;
      p.rot[16*k +: 16] = clamp16((r[k] < 0) ? -q : q);
    end
    return p;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(1, 3);
  endfunction

  // output side: random back-pressure, compare at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        pose_t e;
        e = expected_poses.pop_front();
        n_results++;
        if (out_rotation_o !== e.rot) begin
          $error("out_rotation exp %h got %h", e.rot, out_rotation_o); fail_cnt++;
        end
        if (out_position_o !== e.pos) begin
          $error("out_position exp %h got %h", e.pos, out_position_o); fail_cnt++;
        end
        if (out_scale_o !== e.scl) begin
          $error("out_scale exp %h got %h", e.scl, out_scale_o); fail_cnt++;
        end
        if (blended_o !== e.blend) begin
          $error("blended exp %b got %b", e.blend, blended_o); fail_cnt++;
        end
        if (final_bone_o !== e.last) begin
          $error("final_bone exp %b got %b", e.last, final_bone_o); fail_cnt++;
        end
      end
    end
  end

  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (!stall_on) out_ready_i <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BONE_MASK) mask_q = val;
    else if (idx == REG_BLEND_WEIGHT) weight_q = val[15:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    int guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_poses.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (70) @(posedge clk_i);
  endtask

  // optional check against a typed-in result; valid stays high when no gap
  task automatic send_bone(bone_t b, logic has_exp, pose_t e);
    pose_t p;
    int g;
    p = blend_pose(b);
    if (has_exp && p != e) begin
      $error("directed row: predictor disagrees with table, bone %0d", b.idx);
      fail_cnt++;
    end
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    bone_index_i    <= b.idx;
    base_rotation_i <= b.brot;
    over_rotation_i <= b.orot;
    base_position_i <= b.bpos;
    over_position_i <= b.opos;
    base_scale_i    <= b.bscl;
    over_scale_i    <= b.oscl;
    last_bone_i     <= b.last;
    do @(posedge clk_i); while (!in_ready_o);
    expected_poses.push_back(p);
    n_bones++;
    if (p.blend) n_blended++;
  endtask

  function automatic logic [63:0] rand_quat();
    logic [63:0] q;
    case ($urandom_range(0, 5))
      0: q = {$urandom(), $urandom()};
      1: q = {16'(16384), 48'd0};
      2: q = {16'(-16384), 48'd0};
      default: for (int k = 0; k < 4; k++) q[16*k +: 16] = 16'($urandom_range(0, 16384)
               - (($urandom_range(0, 1) != 0) ? 16384 : 0));
    endcase
    return q;
  endfunction

  function automatic logic [47:0] rand_vec();
    if ($urandom_range(0, 3) == 0) return 48'({$urandom(), $urandom()});
    return {16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 2000) - 1000),
            16'($urandom_range(0, 2000) - 1000)};
  endfunction

  row_t dir_rows[$];

  function automatic row_t mk(logic [7:0] idx, logic [63:0] br, logic [63:0] orr,
                              logic [47:0] v, logic [47:0] w, logic last);
    row_t r;
    r.b = '{idx, br, orr, v, w, w, v, last};
    r.has_exp = 1'b0;
    r.e = '{64'd0, 48'd0, 48'd0, 1'b0, 1'b0};
    return r;
  endfunction

  initial begin
    row_t r;
    bone_t b;
    logic [31:0] masks[6];
    logic [15:0] weights[6];
    mask_q = BONE_MASK_RST;
    weight_q = WEIGHT_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero weight after reset: base passes through, values typed in
    r = mk(8'd0, 64'h4000_0000_0000_0000, 64'h0000_0000_0000_4000,
           48'h7FFF_8000_0001, 48'h8000_7FFF_FFFF, 1'b1);
    r.has_exp = 1'b1;
    r.e = '{64'h4000_0000_0000_0000, 48'h7FFF_8000_0001, 48'h8000_7FFF_FFFF,
            1'b0, 1'b1};
    dir_rows.push_back(r);
    foreach (dir_rows[i]) send_bone(dir_rows[i].b, dir_rows[i].has_exp, dir_rows[i].e);
    dir_rows.delete();
    drain();

    // full weight, extremes, opposite and cancelling quats
    write_reg(REG_BLEND_WEIGHT, 32'd32768);
    dir_rows.push_back(mk(8'd1, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000,
                          48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 1'b0));
    dir_rows.push_back(mk(8'd255, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                          48'h7FFF_0000_8000, 48'h8000_FFFF_7FFF, 1'b1));
    dir_rows.push_back(mk(8'd31, 64'h0, 64'h0, 48'h0, 48'h0, 1'b0));
    dir_rows.push_back(mk(8'd32, 64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000,
                          48'h0001_FFFF_0100, 48'hFF00_0001_0000, 1'b0));
    foreach (dir_rows[i]) send_bone(dir_rows[i].b, 1'b0, dir_rows[i].e);
    dir_rows.delete();
    drain();
    write_reg(REG_BLEND_WEIGHT, 32'hFFFF);
    write_reg(REG_BONE_MASK, 32'h8000_0001);
    // above-one weight, clamped to full, on exactly opposed quats with a dot < 0
    dir_rows.push_back(mk(8'd0, 64'h0000_0000_0000_4000, 64'h0000_0000_0000_C000,
                          48'h1234_5678_9ABC, 48'hFFFF_0000_1111, 1'b0));
    dir_rows.push_back(mk(8'd1, 64'h1, 64'h2, 48'h1, 48'h2, 1'b0));
    dir_rows.push_back(mk(8'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1_0001_0001_0001,
                          48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 1'b0));
    dir_rows.push_back(mk(8'd40, 64'h4000, 64'h4000_0000, 48'h5, 48'h6, 1'b1));
    foreach (dir_rows[i]) send_bone(dir_rows[i].b, 1'b0, dir_rows[i].e);
    dir_rows.delete();
    drain();

    // six mask/weight settings, extremes included, 690 random bones in all
    masks   = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 32'h5555_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    weights = '{16'd16384, 16'd1, 16'd32767, 16'd0, 16'd40000, 16'd9000};
    for (int ph = 0; ph < 6; ph++) begin
      stall_on = (ph != 2);
      write_reg(REG_BONE_MASK, (ph == 5) ? $urandom() : masks[ph]);
      write_reg(REG_BLEND_WEIGHT, (ph == 5) ? $urandom_range(0, 65535) : weights[ph]);
      for (int i = 0; i < 115; i++) begin
        b.idx  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 31)) : 8'($urandom());
        b.brot = rand_quat();
        b.orot = rand_quat();
        b.bpos = rand_vec();
        b.opos = rand_vec();
        b.bscl = rand_vec();
        b.oscl = rand_vec();
        b.last = ($urandom_range(0, 7) == 0);
        send_bone(b, 1'b0, r.e);
      end
      drain();
    end

    $display("Covered %0d bones (%0d blended, %0d results checked) over the directed",
             n_bones, n_blended, n_results);
    $display("and six random mask/weight settings, zero, one and above-one weight included.");
    if (fail_cnt == 0 && expected_poses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
